// ===== rtl/ihds_pkg.sv =====
// Shared types, constants and helpers for the image header dimension sniffer.
package ihds_pkg;

  // Format code carried in the result
  typedef enum logic [1:0] {
    FMT_UNKNOWN = 2'd0,
    FMT_PNG     = 2'd1,
    FMT_GIF     = 2'd2,
    FMT_JPEG    = 2'd3
  } format_e;

  // Bit positions in the magic candidate flags
  localparam int unsigned MagicPng   = 0;
  localparam int unsigned MagicGif87 = 1;
  localparam int unsigned MagicGif89 = 2;
  localparam int unsigned MagicJpeg  = 3;

  localparam logic [3:0] MagicAllAlive = 4'hF;

  // Magic signatures, padded to eight bytes; only the leading bytes are compared
  localparam logic [0:7][7:0] PngSig   = {8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [0:7][7:0] Gif87Sig = {8'h47, 8'h49, 8'h46, 8'h38,
                                          8'h37, 8'h61, 8'h00, 8'h00};
  localparam logic [0:7][7:0] Gif89Sig = {8'h47, 8'h49, 8'h46, 8'h38,
                                          8'h39, 8'h61, 8'h00, 8'h00};
  localparam logic [0:7][7:0] JpegSig  = {8'hFF, 8'hD8, 8'h00, 8'h00,
                                          8'h00, 8'h00, 8'h00, 8'h00};

  localparam int unsigned PngSigLen  = 8;
  localparam int unsigned GifSigLen  = 6;
  localparam int unsigned JpegSigLen = 2;

  // JPEG marker constants
  localparam logic [7:0] JpegMarkerPrefix = 8'hFF;
  localparam logic [7:0] SofFirst         = 8'hC0;
  localparam logic [7:0] SofLast          = 8'hCF;
  localparam logic [7:0] MarkerDht        = 8'hC4;
  localparam logic [7:0] MarkerJpg        = 8'hC8;
  localparam logic [7:0] MarkerDac        = 8'hCC;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic        dims_valid;
    logic [1:0]  image_format;
    logic [30:0] image_width;
    logic [30:0] image_height;
  } out_item_t;

  // Per-file parse state that does not depend on the header window size
  typedef struct packed {
    format_e          detected_format;
    logic [3:0]       magic_flags;
    logic [31:0]      width;
    logic [31:0]      height;
    logic             dims_found;
    logic             parse_error;
    logic [0:8][7:0]  window;      // last nine header bytes, oldest first
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    detected_format: FMT_UNKNOWN,
    magic_flags:     MagicAllAlive,
    width:           32'd0,
    height:          32'd0,
    dims_found:      1'b0,
    parse_error:     1'b0,
    window:          '0
  };

  // Start-of-frame marker: C0..CF except DHT, JPG and DAC
  function automatic logic is_sof(logic [7:0] marker);
    return (marker >= SofFirst) && (marker <= SofLast) && (marker != MarkerDht) &&
           (marker != MarkerJpg) && (marker != MarkerDac);
  endfunction

  // Format chosen by the surviving magic candidates, in priority order
  function automatic format_e format_from_flags(logic [3:0] flags);
    format_e fmt;
    if (flags[MagicPng]) begin
      fmt = FMT_PNG;
    end else if (flags[MagicGif87] || flags[MagicGif89]) begin
      fmt = FMT_GIF;
    end else if (flags[MagicJpeg]) begin
      fmt = FMT_JPEG;
    end else begin
      fmt = FMT_UNKNOWN;
    end
    return fmt;
  endfunction

  // Dimension is usable when it lies in 1 .. 2^31-1
  function automatic logic dim_ok(logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

endpackage

// ===== rtl/image_header_dimension_sniffer.sv =====
// Top level of the image header dimension sniffer: channel registers and per-file state.
//
// Usage: feed an image file one byte per input transaction, with last_byte set on the
// final byte. The block recognizes PNG, GIF87a/89a and JPEG from the magic bytes and
// returns one output transaction per file, on its last byte, with the format code,
// the width and height, and dims_valid. Bytes past the first HEADER_BYTES are
// accepted but not examined or counted. After each result the block starts over on a new file.
//
// Throughput: one byte per cycle, sustained, except while a last byte waits for the output
// register. Each byte passes an input register, then compare-and-select logic that updates
// the parse state (a nine-byte shift window, the magic flags, the dimension registers and
// the JPEG segment pointer). The result is registered: out_valid_o rises once the last
// byte leaves the input register, and the result is held in the output register.
// Reset clears the parse state to a fresh file and empties both channel registers.
// When the receiver stalls, ordinary bytes keep flowing; only a last byte waits in the
// input register until the output register is free, and in_ready_o is low while it waits.
module image_header_dimension_sniffer #(
  parameter int unsigned HEADER_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ihds_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ihds_pkg::out_item_t  out_item_o
);

  localparam int unsigned PosW = $clog2(HEADER_BYTES + 1);
  localparam int unsigned SegW = $clog2(HEADER_BYTES + 65547);
  localparam logic [SegW-1:0] SegReset = SegW'(2);

  logic                   in_valid_q;
  ihds_pkg::in_item_t     in_item_q;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [SegW-1:0]        seg_q, seg_d;
  ihds_pkg::parse_state_t st_q, st_d;
  logic                   out_valid_q;
  ihds_pkg::out_item_t    out_item_q, result;
  logic                   out_free, fire;
  ihds_pkg::format_e      fmt;
  logic                   valid;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && (!in_item_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || fire;

  // Byte step logic
  ihds_step #(
    .HeaderBytes(HEADER_BYTES)
  ) u_step (
    .pos_i  (pos_q),
    .seg_i  (seg_q),
    .state_i(st_q),
    .byte_i (in_item_q.data_byte),
    .pos_o  (pos_d),
    .seg_o  (seg_d),
    .state_o(st_d)
  );

  // Form the result from the state after the last byte
  always_comb begin
    fmt   = (pos_d >= PosW'(10)) ? st_d.detected_format : ihds_pkg::FMT_UNKNOWN;
    valid = (fmt != ihds_pkg::FMT_UNKNOWN) && st_d.dims_found && !st_d.parse_error &&
            ihds_pkg::dim_ok(st_d.width) && ihds_pkg::dim_ok(st_d.height);
    result.dims_valid   = valid;
    result.image_format = fmt;
    result.image_width  = valid ? st_d.width[30:0] : 31'd0;
    result.image_height = valid ? st_d.height[30:0] : 31'd0;
  end

  // Hold the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // Advance parse state; start over after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      seg_q <= SegReset;
      st_q  <= ihds_pkg::StateReset;
    end else if (fire) begin
      if (in_item_q.last_byte) begin
        pos_q <= '0;
        seg_q <= SegReset;
        st_q  <= ihds_pkg::StateReset;
      end else begin
        pos_q <= pos_d;
        seg_q <= seg_d;
        st_q  <= st_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_item_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_item_q.last_byte) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/ihds_step.sv =====
// Next-state logic for one header byte: magic match, PNG/GIF fields, JPEG segment walk.
module ihds_step #(
  parameter int unsigned HeaderBytes = 4096
) (
  input  logic [$clog2(HeaderBytes+1)-1:0]     pos_i,
  input  logic [$clog2(HeaderBytes+65547)-1:0] seg_i,
  input  ihds_pkg::parse_state_t               state_i,
  input  logic [7:0]                           byte_i,
  output logic [$clog2(HeaderBytes+1)-1:0]     pos_o,
  output logic [$clog2(HeaderBytes+65547)-1:0] seg_o,
  output ihds_pkg::parse_state_t               state_o
);

  localparam int unsigned PosW = $clog2(HeaderBytes + 1);
  localparam int unsigned SegW = $clog2(HeaderBytes + 65547);

  logic             take;
  logic [3:0]       flags_n;
  logic [0:9][7:0]  w;
  logic [15:0]      seg_len;
  logic [SegW-1:0]  pos_ext;
  logic [2:0]       sig_idx;

  assign take    = pos_i < PosW'(HeaderBytes);
  assign sig_idx = pos_i[2:0];
  assign w       = {state_i.window, byte_i};
  assign seg_len = {w[2], w[3]};
  assign pos_ext = SegW'(pos_i);

  // Drop magic candidates that mismatch at this position
  always_comb begin
    flags_n = state_i.magic_flags;
    if (pos_i < PosW'(ihds_pkg::PngSigLen) && byte_i != ihds_pkg::PngSig[sig_idx]) begin
      flags_n[ihds_pkg::MagicPng] = 1'b0;
    end
    if (pos_i < PosW'(ihds_pkg::GifSigLen) && byte_i != ihds_pkg::Gif87Sig[sig_idx]) begin
      flags_n[ihds_pkg::MagicGif87] = 1'b0;
    end
    if (pos_i < PosW'(ihds_pkg::GifSigLen) && byte_i != ihds_pkg::Gif89Sig[sig_idx]) begin
      flags_n[ihds_pkg::MagicGif89] = 1'b0;
    end
    if (pos_i < PosW'(ihds_pkg::JpegSigLen) && byte_i != ihds_pkg::JpegSig[sig_idx]) begin
      flags_n[ihds_pkg::MagicJpeg] = 1'b0;
    end
  end

  // Update state for the byte; hold everything past the header window
  always_comb begin
    pos_o   = pos_i;
    seg_o   = seg_i;
    state_o = state_i;
    if (take) begin
      pos_o               = pos_i + PosW'(1);
      state_o.window      = {state_i.window[1:8], byte_i};
      state_o.magic_flags = flags_n;
      if (pos_i == PosW'(9)) begin
        state_o.detected_format = ihds_pkg::format_from_flags(flags_n);
      end

      if (flags_n[ihds_pkg::MagicPng]) begin
        // PNG: big-endian words at 16 and 20
        if (pos_i >= PosW'(16) && pos_i <= PosW'(19)) begin
          state_o.width = {state_i.width[23:0], byte_i};
        end
        if (pos_i >= PosW'(20) && pos_i <= PosW'(23)) begin
          state_o.height = {state_i.height[23:0], byte_i};
        end
        if (pos_i == PosW'(23)) begin
          state_o.dims_found = 1'b1;
        end
      end else if (flags_n[ihds_pkg::MagicGif87] || flags_n[ihds_pkg::MagicGif89]) begin
        // GIF: little-endian halves at 6 and 8
        if (pos_i == PosW'(6)) begin
          state_o.width = {24'd0, byte_i};
        end
        if (pos_i == PosW'(7)) begin
          state_o.width = state_i.width | {16'd0, byte_i, 8'd0};
        end
        if (pos_i == PosW'(8)) begin
          state_o.height = {24'd0, byte_i};
        end
        if (pos_i == PosW'(9)) begin
          state_o.height     = state_i.height | {16'd0, byte_i, 8'd0};
          state_o.dims_found = 1'b1;
        end
      end else if (flags_n[ihds_pkg::MagicJpeg] && pos_i >= PosW'(11)) begin
        // JPEG: examine the segment once its ten-byte window is complete
        if (!state_i.dims_found && !state_i.parse_error &&
            pos_ext == seg_i + SegW'(9)) begin
          if (w[0] != ihds_pkg::JpegMarkerPrefix) begin
            state_o.parse_error = 1'b1;
          end else if (ihds_pkg::is_sof(w[1])) begin
            state_o.height     = {16'd0, w[5], w[6]};
            state_o.width      = {16'd0, w[7], w[8]};
            state_o.dims_found = 1'b1;
          end else if (seg_len < 16'd2) begin
            state_o.parse_error = 1'b1;
          end else begin
            seg_o = seg_i + SegW'(2) + SegW'(seg_len);
          end
        end
      end
    end
  end

endmodule

// ===== tb/image_header_dimension_sniffer_test.sv =====
// Self-checking testbench for the image header dimension sniffer: files of bytes in, dims out.
`timescale 1ns / 1ps

module image_header_dimension_sniffer_test;

  localparam int unsigned HdrBytes   = 4096;
  localparam int unsigned RandItems  = 1400;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 10;

  // Signatures and JPEG marker codes
  localparam logic [0:7][7:0] PngMagic   = {8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [0:5][7:0] Gif87Magic = {8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61};
  localparam logic [0:5][7:0] Gif89Magic = {8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61};
  localparam logic [0:1][7:0] JpegMagic  = {8'hFF, 8'hD8};
  localparam logic [7:0] MarkerLead = 8'hFF;
  localparam logic [7:0] SofLo      = 8'hC0;
  localparam logic [7:0] SofHi      = 8'hCF;
  localparam logic [7:0] DhtMarker  = 8'hC4;
  localparam logic [7:0] JpgMarker  = 8'hC8;
  localparam logic [7:0] DacMarker  = 8'hCC;

  // One queued byte, or a marker that holds the sender until all results are in
  typedef struct packed {
    ihds_pkg::in_item_t  item;
    logic                typed;
    ihds_pkg::out_item_t exp;
    logic                pause;
  } send_t;

  // Directed row: a byte and, where obvious, the result it must close with
  typedef struct packed {
    logic [7:0]          data;
    logic                is_last;
    logic                typed;
    ihds_pkg::out_item_t exp;
  } dir_row_t;

  localparam ihds_pkg::out_item_t NoDims = '{1'b0, ihds_pkg::FMT_UNKNOWN, 31'd0, 31'd0};

  localparam dir_row_t DirTable [24] = '{
    // one-byte file: too short for anything
    '{8'h00, 1'b1, 1'b1, NoDims},
    // GIF89a with both dimensions at their largest
    '{8'h47, 1'b0, 1'b0, '0}, '{8'h49, 1'b0, 1'b0, '0}, '{8'h46, 1'b0, 1'b0, '0},
    '{8'h38, 1'b0, 1'b0, '0}, '{8'h39, 1'b0, 1'b0, '0}, '{8'h61, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{1'b1, ihds_pkg::FMT_GIF, 31'd65535, 31'd65535}},
    // GIF87a with zero width: format kept, dims dropped
    '{8'h47, 1'b0, 1'b0, '0}, '{8'h49, 1'b0, 1'b0, '0}, '{8'h46, 1'b0, 1'b0, '0},
    '{8'h38, 1'b0, 1'b0, '0}, '{8'h37, 1'b0, 1'b0, '0}, '{8'h61, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h05, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{1'b0, ihds_pkg::FMT_GIF, 31'd0, 31'd0}},
    // JPEG prefix cut short
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hD8, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, NoDims}
  };

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  ihds_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ihds_pkg::out_item_t out_item_o;

  send_t               stim_q[$];
  ihds_pkg::out_item_t pending_dims[$];
  logic [7:0]          fbuf[$];
  send_t               cur_send = '0;
  int unsigned         rand_items = 0;
  int unsigned         fail_cnt = 0;

  // Sniffer state as the testbench sees it
  int unsigned       hdr_pos;
  logic [7:0]        win_bytes [10];
  ihds_pkg::format_e fmt_seen;
  logic [3:0]        magic_alive;
  int unsigned       seg_ptr;
  logic [31:0]       dim_w;
  logic [31:0]       dim_h;
  logic              frame_seen;
  logic              chain_broken;

  image_header_dimension_sniffer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Return the per-file state to a fresh file
  task automatic clear_file_state();
    hdr_pos = 0;
    for (int k = 0; k < 10; k++) win_bytes[k] = 8'h00;
    fmt_seen = ihds_pkg::FMT_UNKNOWN;
    magic_alive = 4'hF;
    seg_ptr = 2;
    dim_w = '0;
    dim_h = '0;
    frame_seen = 1'b0;
    chain_broken = 1'b0;
  endtask

  // Examine the JPEG segment whose ten-byte window just completed
  task automatic walk_segment();
    logic [7:0]  mk;
    logic [15:0] seg_len;
    mk = win_bytes[1];
    seg_len = {win_bytes[2], win_bytes[3]};
    if (win_bytes[0] != MarkerLead) begin
      chain_broken = 1'b1;
    end else if (mk >= SofLo && mk <= SofHi && mk != DhtMarker && mk != JpgMarker &&
                 mk != DacMarker) begin
      dim_h = {16'd0, win_bytes[5], win_bytes[6]};
      dim_w = {16'd0, win_bytes[7], win_bytes[8]};
      frame_seen = 1'b1;
    end else if (seg_len < 16'd2) begin
      chain_broken = 1'b1;
    end else begin
      seg_ptr += 2 + seg_len;
    end
  endtask

  // Advance the sniffer by one byte; on the last byte produce the result
  task automatic sniff_byte(input logic [7:0] b, input logic is_last,
                            output logic got, output ihds_pkg::out_item_t res);
    int unsigned       p;
    ihds_pkg::format_e fmt;
    logic              ok;
    got = 1'b0;
    res = '0;
    if (hdr_pos < HdrBytes) begin
      p = hdr_pos;
      for (int k = 0; k < 9; k++) win_bytes[k] = win_bytes[k + 1];
      win_bytes[9] = b;
      if (p < 8) begin
        if (b != PngMagic[p[2:0]]) magic_alive[0] = 1'b0;
      end
      if (p < 6) begin
        if (b != Gif87Magic[p[2:0]]) magic_alive[1] = 1'b0;
        if (b != Gif89Magic[p[2:0]]) magic_alive[2] = 1'b0;
      end
      if (p < 2) begin
        if (b != JpegMagic[p[0]]) magic_alive[3] = 1'b0;
      end
      if (p == 9) begin
        if (magic_alive[0]) fmt_seen = ihds_pkg::FMT_PNG;
        else if (magic_alive[1] || magic_alive[2]) fmt_seen = ihds_pkg::FMT_GIF;
        else if (magic_alive[3]) fmt_seen = ihds_pkg::FMT_JPEG;
        else fmt_seen = ihds_pkg::FMT_UNKNOWN;
      end
      if (magic_alive[0]) begin
        if (p >= 16 && p <= 19) dim_w = {dim_w[23:0], b};
        if (p >= 20 && p <= 23) dim_h = {dim_h[23:0], b};
        if (p == 23) frame_seen = 1'b1;
      end else if (magic_alive[1] || magic_alive[2]) begin
        if (p == 6) dim_w = {24'd0, b};
        if (p == 7) dim_w[15:8] = b;
        if (p == 8) dim_h = {24'd0, b};
        if (p == 9) begin
          dim_h[15:8] = b;
          frame_seen = 1'b1;
        end
      end else if (magic_alive[3] && p >= 11) begin
        if (!frame_seen && !chain_broken && p == seg_ptr + 9) walk_segment();
      end
      hdr_pos++;
    end
    if (is_last) begin
      fmt = (hdr_pos >= 10) ? fmt_seen : ihds_pkg::FMT_UNKNOWN;
      ok = fmt != ihds_pkg::FMT_UNKNOWN && frame_seen && !chain_broken &&
           dim_w != 0 && !dim_w[31] && dim_h != 0 && !dim_h[31];
      got = 1'b1;
      res.dims_valid   = ok;
      res.image_format = fmt;
      res.image_width  = ok ? dim_w[30:0] : 31'd0;
      res.image_height = ok ? dim_h[30:0] : 31'd0;
      clear_file_state();
    end
  endtask

  // Compare one delivered result with the oldest expectation
  task automatic check_dims(input ihds_pkg::out_item_t act);
    ihds_pkg::out_item_t want;
    if (pending_dims.size() == 0) begin
      $error("result with none expected: valid %0d format %0d %0dx%0d", act.dims_valid,
             act.image_format, act.image_width, act.image_height);
      fail_cnt++;
    end else begin
      want = pending_dims.pop_front();
      if (act.dims_valid !== want.dims_valid) begin
        $error("dims_valid: expected %0d, got %0d", want.dims_valid, act.dims_valid);
        fail_cnt++;
      end
      if (act.image_format !== want.image_format) begin
        $error("image_format: expected %0d, got %0d", want.image_format, act.image_format);
        fail_cnt++;
      end
      if (act.image_width !== want.image_width) begin
        $error("image_width: expected %0d, got %0d", want.image_width, act.image_width);
        fail_cnt++;
      end
      if (act.image_height !== want.image_height) begin
        $error("image_height: expected %0d, got %0d", want.image_height, act.image_height);
        fail_cnt++;
      end
    end
  endtask

  // Queue building: bytes gather in fbuf and leave as one file
  task automatic queue_byte(input logic [7:0] b, input logic is_last);
    send_t s;
    s = '0;
    s.item.data_byte = b;
    s.item.last_byte = is_last;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic emit_file();
    for (int k = 0; k < fbuf.size(); k++) queue_byte(fbuf[k], k == fbuf.size() - 1);
    rand_items += fbuf.size();
    fbuf.delete();
  endtask

  task automatic queue_pause();
    send_t s;
    s = '0;
    s.pause = 1'b1;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic put_byte(input logic [7:0] b);
    fbuf.insert(fbuf.size(), b);
  endtask

  task automatic put_rand(input int unsigned n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_be16(input logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic trim_to(input int unsigned n);
    while (fbuf.size() > n) void'(fbuf.pop_back());
  endtask

  function automatic logic [31:0] pick_dim32();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000 | $urandom;
      4: return 32'hFFFF_FFFF;
      5: return $urandom;
      default: return $urandom_range(1, 4000);
    endcase
  endfunction

  function automatic logic [15:0] pick_dim16();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'h8000;
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic logic [7:0] pick_sof();
    logic [7:0] m;
    do m = 8'($urandom_range(SofLo, SofHi));
    while (m == DhtMarker || m == JpgMarker || m == DacMarker);
    return m;
  endfunction

  // Markers that do not end the walk, plus the odd random one
  function automatic logic [7:0] pick_plain_marker();
    case ($urandom_range(0, 7))
      0: return DhtMarker;
      1: return JpgMarker;
      2: return DacMarker;
      3: return 8'hDB;
      4: return 8'hFE;
      5: return 8'hE0 + 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_frame();
    put_byte(MarkerLead);
    put_byte(pick_sof());
    put_be16(16'd17);
    put_byte(8'd8);
    put_be16(pick_dim16());
    put_be16(pick_dim16());
    put_byte(8'd3);
  endtask

  task automatic build_png(input logic cut);
    logic [31:0] w;
    logic [31:0] h;
    w = pick_dim32();
    h = pick_dim32();
    for (int k = 0; k < 8; k++) put_byte(PngMagic[k]);
    put_rand(8);
    for (int k = 3; k >= 0; k--) put_byte(w[8*k +: 8]);
    for (int k = 3; k >= 0; k--) put_byte(h[8*k +: 8]);
    put_rand($urandom_range(0, 12));
    if (cut) trim_to($urandom_range(1, 23));
  endtask

  task automatic build_gif(input logic cut);
    logic [15:0] w;
    logic [15:0] h;
    w = pick_dim16();
    h = pick_dim16();
    for (int k = 0; k < 6; k++) put_byte($urandom_range(0, 1) ? Gif87Magic[k] : Gif89Magic[k]);
    put_byte(w[7:0]);
    put_byte(w[15:8]);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
    put_rand($urandom_range(0, 12));
    if (cut) trim_to($urandom_range(1, 9));
  endtask

  // JPEG: a chain of ordinary segments, then a frame or one of the ways to fail
  task automatic build_jpeg();
    int unsigned seg_len;
    int unsigned mark;
    put_byte(JpegMagic[0]);
    put_byte(JpegMagic[1]);
    repeat ($urandom_range(0, 4)) begin
      seg_len = $urandom_range(2, 24);
      put_byte(MarkerLead);
      put_byte(pick_plain_marker());
      put_be16(seg_len[15:0]);
      put_rand(seg_len - 2);
    end
    case ($urandom_range(0, 10))
      6: begin
        put_byte(8'($urandom_range(0, 254)));
        put_rand($urandom_range(9, 15));
      end
      7: begin
        put_byte(MarkerLead);
        put_byte(8'hE0);
        put_be16(16'($urandom_range(0, 1)));
        put_rand($urandom_range(6, 12));
      end
      8: begin
        put_byte(MarkerLead);
        put_byte(8'hE1);
        put_be16(16'($urandom_range(16'h0100, 16'hFFFF)));
        put_rand($urandom_range(6, 30));
      end
      9: begin
        mark = fbuf.size();
        put_frame();
        trim_to(mark + $urandom_range(0, 9));
      end
      10: put_rand($urandom_range(0, 3));
      default: begin
        put_frame();
        put_rand($urandom_range(0, 8));
      end
    endcase
  endtask

  // Random bytes, or a signature with one bit flipped
  task automatic build_noise();
    int unsigned pos;
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < 8; k++) put_byte(PngMagic[k]);
      1: for (int k = 0; k < 6; k++) put_byte(Gif89Magic[k]);
      2: for (int k = 0; k < 2; k++) put_byte(JpegMagic[k]);
      default: put_rand($urandom_range(1, 10));
    endcase
    pos = $urandom_range(0, fbuf.size() - 1);
    fbuf[pos] = fbuf[pos] ^ (8'd1 << $urandom_range(0, 7));
    put_rand($urandom_range(0, 30));
  endtask

  task automatic build_short();
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < 8; k++) put_byte(PngMagic[k]);
      1: for (int k = 0; k < 6; k++) put_byte(Gif87Magic[k]);
      2: for (int k = 0; k < 2; k++) put_byte(JpegMagic[k]);
      default: put_rand(9);
    endcase
    put_rand(9);
    trim_to($urandom_range(1, 9));
  endtask

  task automatic build_random_file();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) build_png(1'b0);
    else if (pick < 25) build_png(1'b1);
    else if (pick < 40) build_gif(1'b0);
    else if (pick < 45) build_gif(1'b1);
    else if (pick < 80) build_jpeg();
    else if (pick < 90) build_noise();
    else build_short();
    emit_file();
  endtask

  // Sender, input monitor and result checker share one process
  always @(posedge clk_i or negedge rst_ni) begin : feed_and_check
    logic                got;
    ihds_pkg::out_item_t res;
    send_t               nxt;
    int unsigned         burst_left;
    int unsigned         gap_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      cur_send   <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // predict on each accepted byte
      if (in_valid_i && in_ready_o) begin
        sniff_byte(in_item_i.data_byte, in_item_i.last_byte, got, res);
        if (got) pending_dims.insert(pending_dims.size(), cur_send.typed ? cur_send.exp : res);
      end
      if (out_valid_o && out_ready_i) check_dims(out_item_o);
      // drive the next byte once the channel is free
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (stim_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (stim_q[0].pause) begin
          in_valid_i <= 1'b0;
          if (pending_dims.size() == 0) void'(stim_q.pop_front());
        end else begin
          nxt = stim_q.pop_front();
          in_valid_i <= 1'b1;
          in_item_i  <= nxt.item;
          cur_send   <= nxt;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 80);
            case ($urandom_range(0, 3))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(1, 10);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: switch between open, random, sparse and toggling stretches
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    rx_mode_e    mode;
    int unsigned mode_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 7) == 0);
        default:   out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : run
    send_t s;
    logic  paused;
    clear_file_state();
    paused = 1'b0;
    // directed table first
    foreach (DirTable[i]) begin
      s = '0;
      s.item.data_byte = DirTable[i].data;
      s.item.last_byte = DirTable[i].is_last;
      s.typed = DirTable[i].typed;
      s.exp   = DirTable[i].exp;
      stim_q.insert(stim_q.size(), s);
    end
    // random files, with one full drain halfway through
    while (rand_items < RandItems) begin
      if (!paused && rand_items >= RandItems / 2) begin
        queue_pause();
        paused = 1'b1;
      end
      build_random_file();
    end
    queue_pause();
    repeat (5) build_random_file();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain, then let any stray result show up
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || pending_dims.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
    if (fail_cnt == 0 && pending_dims.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
